// ----- hdl/i2of5_pkg.sv -----
package i2of5_pkg;

  // field widths
  localparam int unsigned WidthW   = 15;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned PatternW = 20;
  localparam int unsigned PosW     = 4;

  typedef logic [WidthW-1:0]   width_t;
  typedef logic [DigitW-1:0]   digit_t;
  typedef logic [PatternW-1:0] pattern_t;
  typedef logic [PosW-1:0]     pos_t;

  // element codes as shifted into the pattern
  typedef enum logic [1:0] {
    CODE_NARROW_BAR   = 2'd0,
    CODE_WIDE_BAR     = 2'd1,
    CODE_NARROW_SPACE = 2'd2,
    CODE_WIDE_SPACE   = 2'd3
  } elem_code_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_START = 2'd1,
    STATUS_BAD_PAIR = 2'd2,
    STATUS_NO_STOP  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PHASE_START = 2'd0,
    PHASE_PAIRS = 2'd1,
    PHASE_STOP  = 2'd2
  } phase_e;

  typedef enum logic [0:0] {
    CFG_BAR_THRESHOLD   = 1'b0,
    CFG_SPACE_THRESHOLD = 1'b1
  } cfg_idx_e;

  localparam pattern_t START_PATTERN  = 20'h00022;
  localparam pattern_t STOP_PATTERN   = 20'h00063;
  localparam pos_t     GROUP_ELEMENTS = 4'd10;
  localparam pos_t     EDGE_ELEMENTS  = 4'd4;
  localparam digit_t   NO_DIGIT       = 4'd15;

  // pair decoder result
  typedef struct packed {
    logic   ok;
    digit_t first;
    digit_t second;
  } pair_dec_t;

endpackage

// ----- hdl/i2of5_intf.sv -----
interface i2of5_elem_if;
  import i2of5_pkg::*;
  logic   valid;
  logic   ready;
  width_t element_width;
  logic   is_bar;
  logic   scan_start;

  modport source (output valid, element_width, is_bar, scan_start, input ready);
  modport sink   (input valid, element_width, is_bar, scan_start, output ready);
endinterface

interface i2of5_result_if;
  import i2of5_pkg::*;
  logic       valid;
  logic       ready;
  digit_t     digit_first;
  digit_t     digit_second;
  logic [1:0] status;
  logic       is_final;

  modport source (output valid, digit_first, digit_second, status, is_final, input ready);
  modport sink   (input valid, digit_first, digit_second, status, is_final, output ready);
endinterface

// ----- hdl/i2of5_barcode_decoder_core.sv -----
// Channel   Dir  Payload                                         Accepted when
// elem_i    in   element_width, is_bar, scan_start               valid && ready
// result_o  out  digit_first, digit_second, status, is_final     valid && ready
// cfg       in   cfg_index_i, cfg_wdata_i                        cfg_we_i
//
// One item per cycle while the result side does not stall; an item passes through
// the input register and then the result register, where its result (if any) appears.
// The scan state update (classify, shift, pair decode, mod-10 sum) is one
// combinational pass between those registers.
// Reset clears thresholds and scan state; the block discards until scan start.
// A stalled result holds the input register; the input side keeps taking items
// while the result register drains.
module i2of5_barcode_decoder_core
  import i2of5_pkg::*;
#(
  parameter int unsigned DIGIT_PAIRS = 55
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_index_i,
  input  width_t                cfg_wdata_i,
  i2of5_elem_if.sink            elem_i,
  i2of5_result_if.source        result_o
);

  localparam int unsigned PairW = $clog2(DIGIT_PAIRS + 1);
  typedef logic [PairW-1:0] pair_cnt_t;

  // weighted sum stays below 46, so one subtraction of at most 40 suffices
  function automatic digit_t mod10(input logic [5:0] v);
    logic [5:0] r;
    priority if (v >= 6'd40) r = v - 6'd40;
    else if (v >= 6'd30)     r = v - 6'd30;
    else if (v >= 6'd20)     r = v - 6'd20;
    else if (v >= 6'd10)     r = v - 6'd10;
    else                     r = v;
    return r[3:0];
  endfunction

  // configuration
  width_t bar_thr_q, space_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_thr_q   <= '0;
      space_thr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BAR_THRESHOLD:   bar_thr_q   <= cfg_wdata_i;
        CFG_SPACE_THRESHOLD: space_thr_q <= cfg_wdata_i;
      endcase
    end
  end

  // input register
  logic   s1_valid_q;
  width_t s1_width_q;
  logic   s1_bar_q, s1_start_q;
  logic   s1_adv, s1_fire;
  logic   res_valid_q, res_valid_d;

  assign s1_adv       = !res_valid_q || result_o.ready;
  assign s1_fire      = s1_valid_q && s1_adv;
  assign elem_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (elem_i.ready) begin
      s1_valid_q <= elem_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (elem_i.ready && elem_i.valid) begin
      s1_width_q <= elem_i.element_width;
      s1_bar_q   <= elem_i.is_bar;
      s1_start_q <= elem_i.scan_start;
    end
  end

  // scan state
  pos_t      pos_q, pos_d;
  pattern_t  pat_q, pat_d;
  digit_t    sum_q, sum_d;
  logic      fail_q, fail_d;
  logic      disc_q, disc_d;
  phase_e    phase_q, phase_d;
  pair_cnt_t pair_q, pair_d;

  // result register
  digit_t    res_d1_q, res_d1_d, res_d2_q, res_d2_d;
  status_e   res_status_q, res_status_d;
  logic      res_final_q, res_final_d;
  logic      res_load;

  // working values
  pos_t       pos_b, pos_n;
  pattern_t   pat_b, pat_n;
  digit_t     sum_b, sum3;
  logic       fail_b;
  phase_e     phase_b;
  pair_cnt_t  pair_b, pair_n;
  elem_code_e code;
  pair_dec_t  dec;
  logic [5:0] sum_ext;

  i2of5_pair_decode u_pair_decode (
    .pattern_i (pat_n),
    .dec_o     (dec)
  );

  // classify and shift
  always_comb begin
    pos_b   = s1_start_q ? '0 : pos_q;
    pat_b   = s1_start_q ? '0 : pat_q;
    sum_b   = s1_start_q ? '0 : sum_q;
    fail_b  = s1_start_q ? 1'b0 : fail_q;
    phase_b = s1_start_q ? PHASE_START : phase_q;
    pair_b  = s1_start_q ? '0 : pair_q;
    if (s1_bar_q) code = (s1_width_q < bar_thr_q) ? CODE_NARROW_BAR : CODE_WIDE_BAR;
    else          code = (s1_width_q < space_thr_q) ? CODE_NARROW_SPACE : CODE_WIDE_SPACE;
    pat_n   = {pat_b[PatternW-3:0], code};
    pos_n   = pos_b + pos_t'(1);
    pair_n  = pair_b + pair_cnt_t'(1);
    sum_ext = 6'(sum_b) + 6'({dec.first, 1'b0}) + 6'(dec.first);
    sum3    = mod10(sum_ext);
  end

  // next state and result
  always_comb begin
    pos_d        = pos_q;
    pat_d        = pat_q;
    sum_d        = sum_q;
    fail_d       = fail_q;
    disc_d       = disc_q;
    phase_d      = phase_q;
    pair_d       = pair_q;
    res_load     = 1'b0;
    res_d1_d     = '0;
    res_d2_d     = '0;
    res_status_d = STATUS_OK;
    res_final_d  = 1'b0;

    if (s1_fire && (s1_start_q || !disc_q)) begin
      disc_d  = 1'b0;
      sum_d   = sum_b;
      fail_d  = fail_b;
      phase_d = phase_b;
      pair_d  = pair_b;
      pos_d   = pos_n;
      pat_d   = pat_n;
      unique case (phase_b)
        PHASE_START: begin
          if (pos_n >= EDGE_ELEMENTS) begin
            if (pat_n != START_PATTERN) begin
              res_load     = 1'b1;
              res_final_d  = 1'b1;
              res_status_d = STATUS_NO_START;
              disc_d       = 1'b1;
            end else begin
              phase_d = PHASE_PAIRS;
              pos_d   = '0;
              pat_d   = '0;
            end
          end
        end
        PHASE_PAIRS: begin
          if (pos_n >= GROUP_ELEMENTS) begin
            if (!dec.ok) begin
              res_load     = 1'b1;
              res_final_d  = 1'b1;
              res_status_d = STATUS_BAD_PAIR;
              disc_d       = 1'b1;
            end else begin
              pair_d   = pair_n;
              pos_d    = '0;
              pat_d    = '0;
              res_load = 1'b1;
              res_d1_d = dec.first;
              res_d2_d = dec.second;
              if (pair_n >= pair_cnt_t'(DIGIT_PAIRS)) begin
                // last pair carries the check digit
                if (dec.second != ((sum3 == '0) ? digit_t'(0) : digit_t'(4'd10 - sum3))) begin
                  fail_d = 1'b1;
                end
                sum_d   = sum3;
                phase_d = PHASE_STOP;
              end else begin
                sum_d = mod10(sum_ext + 6'(dec.second));
              end
            end
          end
        end
        default: begin
          if (pos_n >= EDGE_ELEMENTS) begin
            res_load     = 1'b1;
            res_final_d  = 1'b1;
            disc_d       = 1'b1;
            if (pat_n != STOP_PATTERN) res_status_d = STATUS_NO_STOP;
            else if (fail_b)           res_status_d = STATUS_BAD_PAIR;
            else                       res_status_d = STATUS_OK;
          end
        end
      endcase
    end

    if (s1_fire)             res_valid_d = res_load;
    else if (result_o.ready) res_valid_d = 1'b0;
    else                     res_valid_d = res_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      pat_q       <= '0;
      sum_q       <= '0;
      fail_q      <= 1'b0;
      disc_q      <= 1'b1;
      phase_q     <= PHASE_START;
      pair_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      pat_q       <= pat_d;
      sum_q       <= sum_d;
      fail_q      <= fail_d;
      disc_q      <= disc_d;
      phase_q     <= phase_d;
      pair_q      <= pair_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_d1_q     <= res_d1_d;
      res_d2_q     <= res_d2_d;
      res_status_q <= res_status_d;
      res_final_q  <= res_final_d;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.digit_first  = res_d1_q;
  assign result_o.digit_second = res_d2_q;
  assign result_o.status       = res_status_q;
  assign result_o.is_final     = res_final_q;

`ifndef SYNTHESIS
  // a final result always leaves the block discarding
  a_final_discards: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_final_d) |=> disc_q)
    else $error("final result without discarding");

  // pair results carry status ok, final results carry no digits
  a_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.is_final ? (result_o.digit_first == '0 &&
      result_o.digit_second == '0) : (result_o.status == STATUS_OK)))
    else $error("malformed result");

  // the stop pattern is only entered after all pairs
  a_stop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PHASE_STOP) |-> (pair_q == pair_cnt_t'(DIGIT_PAIRS)))
    else $error("stop phase with wrong pair count");

  // a result is only loaded when the result register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_valid_q || result_o.ready))
    else $error("result register overwritten");
`endif

endmodule

// ----- hdl/i2of5_pair_decode.sv -----
module i2of5_pair_decode
  import i2of5_pkg::*;
(
  input  pattern_t  pattern_i,
  output pair_dec_t dec_o
);

  // 2-of-5 code (earliest element in bit 4) to digit
  function automatic digit_t code_to_digit(input logic [4:0] code);
    digit_t d;
    unique case (code)
      5'd3:    d = 4'd7;
      5'd5:    d = 4'd4;
      5'd6:    d = 4'd0;
      5'd9:    d = 4'd2;
      5'd10:   d = 4'd9;
      5'd12:   d = 4'd6;
      5'd17:   d = 4'd1;
      5'd18:   d = 4'd8;
      5'd20:   d = 4'd5;
      5'd24:   d = 4'd3;
      default: d = NO_DIGIT;
    endcase
    return d;
  endfunction

  logic [4:0] bars;
  logic [4:0] spaces;
  logic       kinds_ok;

  // each group element pair is bar then space; k = 0 is the latest pair
  always_comb begin
    kinds_ok = 1'b1;
    for (int k = 0; k < 5; k++) begin
      logic [1:0] sp;
      logic [1:0] br;
      sp = pattern_i[4*k +: 2];
      br = pattern_i[4*k+2 +: 2];
      if (!(sp == CODE_NARROW_SPACE || sp == CODE_WIDE_SPACE) ||
          !(br == CODE_NARROW_BAR || br == CODE_WIDE_BAR)) begin
        kinds_ok = 1'b0;
      end
      spaces[k] = (sp == CODE_WIDE_SPACE);
      bars[k]   = (br == CODE_WIDE_BAR);
    end
  end

  always_comb begin
    dec_o.first  = code_to_digit(bars);
    dec_o.second = code_to_digit(spaces);
    dec_o.ok     = kinds_ok && (dec_o.first != NO_DIGIT) && (dec_o.second != NO_DIGIT);
  end

endmodule

// ----- sim/i2of5_barcode_decoder_core_tb.sv -----
`timescale 1ns / 100ps

module i2of5_barcode_decoder_core_tb;
  import i2of5_pkg::*;

  localparam int unsigned DIGIT_PAIRS    = 55;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_WIDTH      = 32767;
  // start, all pairs and stop of one complete scan
  localparam int unsigned SCAN_ITEMS     = 8 + 10 * DIGIT_PAIRS;

  typedef struct packed {
    digit_t  first;
    digit_t  second;
    status_e status;
    logic    is_final;
  } scan_result_t;

  // Tracks the decoder's scan state and the results it must produce
  class decode_scoreboard;
    width_t       bar_thr;
    width_t       space_thr;
    int unsigned  elem_pos;
    int unsigned  digit_sum;
    int unsigned  pairs_done;
    pattern_t     shift_reg;
    bit           sum_bad;
    bit           discarding;
    phase_e       section;
    scan_result_t expected_q[$];
    int unsigned  errors;

    function new();
      bar_thr    = '0;
      space_thr  = '0;
      errors     = 0;
      clear_scan();
      discarding = 1'b1;
    endfunction

    function void clear_scan();
      elem_pos   = 0;
      digit_sum  = 0;
      pairs_done = 0;
      shift_reg  = '0;
      sum_bad    = 1'b0;
      section    = PHASE_START;
    endfunction

    // 2-of-5 code, first element in bit 4
    function digit_t digit_of(logic [4:0] c);
      digit_t d;
      case (c)
        5'b00110: d = 4'd0;
        5'b10001: d = 4'd1;
        5'b01001: d = 4'd2;
        5'b11000: d = 4'd3;
        5'b00101: d = 4'd4;
        5'b10100: d = 4'd5;
        5'b01100: d = 4'd6;
        5'b00011: d = 4'd7;
        5'b10010: d = 4'd8;
        5'b01010: d = 4'd9;
        default:  d = NO_DIGIT;
      endcase
      return d;
    endfunction

    function void push_final(status_e st);
      expected_q.push_back('{first: '0, second: '0, status: st, is_final: 1'b1});
      discarding = 1'b1;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Called for every accepted element item
    function void note_item(width_t w, logic bar, logic start);
      elem_code_e  code;
      logic [4:0]  bars;
      logic [4:0]  spaces;
      logic [1:0]  sp;
      logic [1:0]  br;
      digit_t      d1;
      digit_t      d2;
      bit          bad;
      int unsigned s;
      if (start) begin
        clear_scan();
        discarding = 1'b0;
      end
      if (discarding) return;

      if (bar) code = (w < bar_thr) ? CODE_NARROW_BAR : CODE_WIDE_BAR;
      else code = (w < space_thr) ? CODE_NARROW_SPACE : CODE_WIDE_SPACE;
      shift_reg = {shift_reg[PatternW-3:0], code};
      elem_pos++;

      case (section)
        PHASE_START: begin
          if (elem_pos < EDGE_ELEMENTS) return;
          if (shift_reg != START_PATTERN) begin
            push_final(STATUS_NO_START);
          end else begin
            section   = PHASE_PAIRS;
            elem_pos  = 0;
            shift_reg = '0;
          end
        end
        PHASE_PAIRS: begin
          if (elem_pos < GROUP_ELEMENTS) return;
          bad    = 1'b0;
          bars   = '0;
          spaces = '0;
          for (int k = 0; k < 5; k++) begin
            sp = shift_reg[4*k +: 2];
            br = shift_reg[4*k+2 +: 2];
            if (sp < 2 || br > 1) bad = 1'b1;
            spaces[k] = (sp == CODE_WIDE_SPACE);
            bars[k]   = (br == CODE_WIDE_BAR);
          end
          d1 = digit_of(bars);
          d2 = digit_of(spaces);
          if (bad || d1 == NO_DIGIT || d2 == NO_DIGIT) begin
            push_final(STATUS_BAD_PAIR);
            return;
          end
          pairs_done++;
          if (pairs_done >= DIGIT_PAIRS) begin
            // last digit is the check digit
            s = (digit_sum + 3 * d1) % 10;
            if (d2 != (10 - s) % 10) sum_bad = 1'b1;
            digit_sum = s;
            section   = PHASE_STOP;
          end else begin
            digit_sum = (digit_sum + 3 * d1 + d2) % 10;
          end
          elem_pos  = 0;
          shift_reg = '0;
          expected_q.push_back('{first: d1, second: d2, status: STATUS_OK, is_final: 1'b0});
        end
        default: begin
          if (elem_pos < EDGE_ELEMENTS) return;
          if (shift_reg != STOP_PATTERN) push_final(STATUS_NO_STOP);
          else if (sum_bad) push_final(STATUS_BAD_PAIR);
          else push_final(STATUS_OK);
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(digit_t f, digit_t s, logic [1:0] st, logic fin);
      scan_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %0d/%0d status %0d final %0b", f, s, st, fin));
        return;
      end
      want = expected_q.pop_front();
      if (f !== want.first)
        report($sformatf("digit_first got %0d want %0d", f, want.first));
      if (s !== want.second)
        report($sformatf("digit_second got %0d want %0d", s, want.second));
      if (st !== want.status)
        report($sformatf("status got %0d want %0d", st, want.status));
      if (fin !== want.is_final)
        report($sformatf("is_final got %0b want %0b", fin, want.is_final));
    endtask
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we_i;
  logic   cfg_index_i;
  width_t cfg_wdata_i;

  i2of5_elem_if   elem_if ();
  i2of5_result_if res_if ();

  decode_scoreboard sb = new();

  bit          idle_on = 1'b1;
  int unsigned items_sent = 0;

  i2of5_barcode_decoder_core #(
    .DIGIT_PAIRS (DIGIT_PAIRS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .elem_i      (elem_if),
    .result_o    (res_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side: ready with random stall bursts
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.digit_first, res_if.digit_second, res_if.status,
                      res_if.is_final);
  end

  // watchdog: too long without any item moving
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((elem_if.valid && elem_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // Width of an element of the given class under the current thresholds
  function automatic width_t elem_width(logic bar, logic wide);
    int unsigned thr;
    int unsigned w;
    thr = bar ? sb.bar_thr : sb.space_thr;
    if (!wide && thr != 0) begin
      case ($urandom_range(0, 7))
        0:       w = 0;
        1:       w = thr - 1;
        default: w = $urandom_range(0, thr - 1);
      endcase
    end else begin
      case ($urandom_range(0, 7))
        0:       w = thr;
        1:       w = MAX_WIDTH;
        default: w = $urandom_range(thr, MAX_WIDTH);
      endcase
    end
    return width_t'(w);
  endfunction

  function automatic logic [4:0] code_of_digit(int unsigned d);
    logic [4:0] c;
    case (d)
      0:       c = 5'b00110;
      1:       c = 5'b10001;
      2:       c = 5'b01001;
      3:       c = 5'b11000;
      4:       c = 5'b00101;
      5:       c = 5'b10100;
      6:       c = 5'b01100;
      7:       c = 5'b00011;
      8:       c = 5'b10010;
      default: c = 5'b01010;
    endcase
    return c;
  endfunction

  // Drive one element item and wait until it is taken
  task automatic send_item(width_t w, logic bar, logic start);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      elem_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    elem_if.valid         <= 1'b1;
    elem_if.element_width <= w;
    elem_if.is_bar        <= bar;
    elem_if.scan_start    <= start;
    do @(posedge clk_i); while (!elem_if.ready);
    sb.note_item(w, bar, start);
    items_sent++;
  endtask

  task automatic send_elem(logic bar, logic wide, logic start);
    send_item(elem_width(bar, wide), bar, start);
  endtask

  task automatic send_start_pattern();
    send_elem(1'b1, 1'b0, 1'b1);
    send_elem(1'b0, 1'b0, 1'b0);
    send_elem(1'b1, 1'b0, 1'b0);
    send_elem(1'b0, 1'b0, 1'b0);
  endtask

  // Ten interleaved elements, bars from one code and spaces from the other
  task automatic send_pair(logic [4:0] bars, logic [4:0] spaces);
    for (int k = 4; k >= 0; k--) begin
      send_elem(1'b1, bars[k], 1'b0);
      send_elem(1'b0, spaces[k], 1'b0);
    end
  endtask

  // wide bar, narrow space, narrow bar, wide space; optionally one class flipped
  task automatic send_stop(bit corrupt);
    logic [3:0] wide_bits;
    wide_bits = 4'b1001;
    if (corrupt) wide_bits[$urandom_range(0, 3)] ^= 1'b1;
    for (int i = 0; i < 4; i++) send_elem(i % 2 == 0, wide_bits[3-i], 1'b0);
  endtask

  // Complete scan; bit 0 of variant spoils the check digit, bit 1 the stop
  task automatic full_scan(int unsigned variant);
    int unsigned sum;
    int unsigned d1;
    int unsigned d2;
    int unsigned chk;
    send_start_pattern();
    sum = 0;
    for (int p = 0; p < DIGIT_PAIRS - 1; p++) begin
      d1 = $urandom_range(0, 9);
      d2 = $urandom_range(0, 9);
      send_pair(code_of_digit(d1), code_of_digit(d2));
      sum = (sum + 3 * d1 + d2) % 10;
    end
    d1  = $urandom_range(0, 9);
    sum = (sum + 3 * d1) % 10;
    chk = (10 - sum) % 10;
    if (variant[0]) chk = (chk + $urandom_range(1, 9)) % 10;
    send_pair(code_of_digit(d1), code_of_digit(chk));
    send_stop(variant[1]);
  endtask

  // Good start, a few pairs, then a broken or cut-off group; room bounds the length
  task automatic broken_scan(int unsigned room);
    int unsigned n;
    int unsigned long_max;
    logic [4:0]  bars;
    logic [4:0]  spaces;
    long_max = (room / 10 > DIGIT_PAIRS - 1) ? DIGIT_PAIRS - 1 : room / 10;
    send_start_pattern();
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, long_max) : $urandom_range(0, 3);
    for (int p = 0; p < n; p++)
      send_pair(code_of_digit($urandom_range(0, 9)), code_of_digit($urandom_range(0, 9)));
    case ($urandom_range(0, 2))
      0: begin
        // element kinds at random
        for (int i = 0; i < 10; i++)
          send_elem(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
      end
      1: begin
        // at least one code without exactly two wide elements
        do begin
          bars   = 5'($urandom);
          spaces = 5'($urandom);
        end while ($countones(bars) == 2 && $countones(spaces) == 2);
        send_pair(bars, spaces);
      end
      default: begin
        // cut short; the next scan start interrupts it
        n = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) send_elem(i % 2 == 0, 1'($urandom_range(0, 1)), 1'b0);
      end
    endcase
  endtask

  task automatic set_thresholds(width_t bar, width_t space);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BAR_THRESHOLD;
    cfg_wdata_i <= bar;
    @(posedge clk_i);
    cfg_index_i <= CFG_SPACE_THRESHOLD;
    cfg_wdata_i <= space;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    sb.bar_thr   = bar;
    sb.space_thr = space;
  endtask

  // Stop sending and let every expected result and the pipeline drain
  task automatic settle();
    elem_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_base;
    int unsigned budget;
    int unsigned room;
    int unsigned full_count;
    int unsigned pick;
    int unsigned n;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_index_i           <= CFG_BAR_THRESHOLD;
    cfg_wdata_i           <= '0;
    elem_if.valid         <= 1'b0;
    elem_if.element_width <= '0;
    elem_if.is_bar        <= 1'b0;
    elem_if.scan_start    <= 1'b0;
    full_count = 0;
    budget     = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: ignored items, bad start, a pair, restart mid-scan
    set_thresholds(15'd100, 15'd200);
    send_item(15'd0, 1'b1, 1'b0);
    send_item(15'd32767, 1'b0, 1'b0);
    send_item(15'd0, 1'b1, 1'b1);
    send_item(15'd32767, 1'b0, 1'b0);
    send_item(15'd99, 1'b1, 1'b0);
    send_item(15'd0, 1'b0, 1'b0);
    send_item(15'd0, 1'b1, 1'b1);
    send_item(15'd199, 1'b0, 1'b0);
    send_item(15'd99, 1'b1, 1'b0);
    send_item(15'd0, 1'b0, 1'b0);
    send_pair(code_of_digit(9), code_of_digit(0));
    send_start_pattern();

    // random phases, each under its own thresholds
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          set_thresholds(15'd1000, 15'd2000);
          budget = 600;
        end
        1: begin
          set_thresholds(15'd32767, 15'd32767);
          budget = 90;
        end
        2: begin
          set_thresholds(15'd0, 15'd0);
          budget = 60;
        end
        3: begin
          set_thresholds(15'd1, 15'd32767);
          budget = 90;
        end
        4: begin
          set_thresholds(width_t'($urandom_range(1, MAX_WIDTH)),
                         width_t'($urandom_range(1, MAX_WIDTH)));
          budget = 110;
        end
        default: begin
          set_thresholds(15'd3, 15'd20000);
          budget = 100;
        end
      endcase
      phase_base = items_sent;
      while (items_sent - phase_base < budget) begin
        room    = budget - (items_sent - phase_base);
        idle_on = (ph != 5) && ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 15);
        if (ph == 0 && items_sent == phase_base) pick = 0;
        if (pick == 0 && sb.bar_thr != 0 && sb.space_thr != 0 && room >= SCAN_ITEMS) begin
          full_scan(full_count % 4);
          full_count++;
        end else if (pick <= 8) begin
          broken_scan(room);
        end else if (pick <= 11) begin
          // start with random elements, mostly a bad start
          send_elem(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
          for (int i = 0; i < 3; i++)
            send_elem(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
        end else begin
          // raw noise, an occasional scan start
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++)
            send_item(width_t'($urandom_range(0, MAX_WIDTH)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 7) == 0);
        end
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
